FILE: rtl/npc_pkg.sv
// Shared types and constants for the nearest palette colour matcher.
// No dependencies; used by the interfaces, the distance unit and the top level.
package npc_pkg;

  localparam int unsigned PalDepthDef = 16;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned OpW         = 2;
  localparam int unsigned EntryIdxW   = 4;
  // Sum of three 8-bit absolute differences, at most 765
  localparam int unsigned DistW       = 10;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_MATCH  = 2'd2
  } npc_op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SCAN  = 3'b100
  } npc_state_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } npc_rgb_t;

endpackage

FILE: rtl/npc_if.sv
// Request and result channel interfaces for the nearest palette colour matcher.
// Depends on npc_pkg for field widths.
interface npc_req_if;
  logic                           valid;
  logic                           ready;
  logic [npc_pkg::OpW-1:0]        operation;
  logic [npc_pkg::ChanW-1:0]      red;
  logic [npc_pkg::ChanW-1:0]      green;
  logic [npc_pkg::ChanW-1:0]      blue;
  logic [npc_pkg::ChanW-1:0]      alpha;

  modport source (output valid, operation, red, green, blue, alpha, input ready);
  modport sink   (input valid, operation, red, green, blue, alpha, output ready);
endinterface

interface npc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [npc_pkg::ChanW-1:0]      out_red;
  logic [npc_pkg::ChanW-1:0]      out_green;
  logic [npc_pkg::ChanW-1:0]      out_blue;
  logic [npc_pkg::ChanW-1:0]      out_alpha;
  logic                           from_palette;
  logic [npc_pkg::EntryIdxW-1:0]  entry_index;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, from_palette,
                  entry_index, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, from_palette,
                  entry_index, output ready);
endinterface

FILE: rtl/npc_dist_unit.sv
// Shared distance unit: Manhattan distance over red, green and blue.
// Depends on npc_pkg for the colour struct and distance width.
module npc_dist_unit (
  input  npc_pkg::npc_rgb_t          pixel_i,
  input  npc_pkg::npc_rgb_t          entry_i,
  output logic [npc_pkg::DistW-1:0]  dist_o
);
  import npc_pkg::*;

  logic [ChanW-1:0] diff_r, diff_g, diff_b;

  always_comb begin
    diff_r = (pixel_i.red   > entry_i.red)   ? pixel_i.red   - entry_i.red
                                             : entry_i.red   - pixel_i.red;
    diff_g = (pixel_i.green > entry_i.green) ? pixel_i.green - entry_i.green
                                             : entry_i.green - pixel_i.green;
    diff_b = (pixel_i.blue  > entry_i.blue)  ? pixel_i.blue  - entry_i.blue
                                             : entry_i.blue  - pixel_i.blue;
    dist_o = DistW'(diff_r) + DistW'(diff_g) + DistW'(diff_b);
  end

endmodule

FILE: rtl/nearest_palette_color.sv
// Nearest palette colour matcher: clear and append requests take effect when accepted.
// A match against an empty palette gives its result in the cycle after acceptance.
// Otherwise a match makes one fetch from the single palette read port, then passes
// one entry per cycle through the shared distance unit, then gives the result.
// Reset (rst_ni low, asynchronous) empties the palette; entries are undefined until
// appended. One request is handled at a time; a waiting result holds off every request.
module nearest_palette_color #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::PalDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  npc_req_if.sink           req_i,
  npc_rsp_if.source         rsp_o
);
  import npc_pkg::*;

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);

  // Control state
  npc_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             first_q, first_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers
  npc_rgb_t         color_q, color_d;
  logic [ChanW-1:0] alpha_q, alpha_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  npc_rgb_t         best_rgb_q, best_rgb_d;
  npc_rgb_t         out_rgb_q, out_rgb_d;
  logic [ChanW-1:0] out_alpha_q, out_alpha_d;
  logic             out_pal_q, out_pal_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;

  // Palette memory
  npc_rgb_t         pal_mem_q [PALETTE_DEPTH];
  npc_rgb_t         rd_data_q;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  npc_rgb_t         wr_data;

  logic             req_ready;
  logic             req_acc;
  logic             scan_last;
  logic             better;
  logic [DistW-1:0] cur_dist;
  logic [IdxW+EntryIdxW-1:0] out_idx_ext;

  npc_dist_unit u_dist (
    .pixel_i (color_q),
    .entry_i (rd_data_q),
    .dist_o  (cur_dist)
  );

  assign req_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_acc   = req_i.valid && req_ready;
  assign scan_last = (CntW'(cmp_idx_q) + CntW'(1)) == count_q;
  assign better    = first_q || (cur_dist < best_dist_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    color_d     = color_q;
    alpha_d     = alpha_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    best_rgb_d  = best_rgb_q;
    out_rgb_d   = out_rgb_q;
    out_alpha_d = out_alpha_q;
    out_pal_d   = out_pal_q;
    out_idx_d   = out_idx_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IdxW-1:0];
    wr_data     = '{red: req_i.red, green: req_i.green, blue: req_i.blue};

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (npc_op_e'(req_i.operation))
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              // Drop the entry once the palette is full
              if (count_q < CntW'(PALETTE_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            OP_MATCH: begin
              color_d = wr_data;
              alpha_d = req_i.alpha;
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_rgb_d   = wr_data;
                out_alpha_d = req_i.alpha;
                out_pal_d   = 1'b0;
                out_idx_d   = '0;
              end else begin
                rd_idx_d = '0;
                state_d  = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        // Entry 0 lands in the read register now; start the next read
        if (rd_idx_q != IdxW'(PALETTE_DEPTH - 1)) rd_idx_d = rd_idx_q + IdxW'(1);
        cmp_idx_d = '0;
        first_d   = 1'b1;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (better) begin
          best_dist_d = cur_dist;
          best_idx_d  = cmp_idx_q;
          best_rgb_d  = rd_data_q;
        end
        first_d = 1'b0;
        if (rd_idx_q != IdxW'(PALETTE_DEPTH - 1)) rd_idx_d = rd_idx_q + IdxW'(1);
        cmp_idx_d = cmp_idx_q + IdxW'(1);
        if (scan_last) begin
          out_valid_d = 1'b1;
          out_rgb_d   = best_rgb_d;
          out_alpha_d = alpha_q;
          out_pal_d   = 1'b1;
          out_idx_d   = best_idx_d;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q     <= color_d;
    alpha_q     <= alpha_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    best_rgb_q  <= best_rgb_d;
    out_rgb_q   <= out_rgb_d;
    out_alpha_q <= out_alpha_d;
    out_pal_q   <= out_pal_d;
    out_idx_q   <= out_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) pal_mem_q[wr_addr] <= wr_data;
    rd_data_q <= pal_mem_q[rd_idx_q];
  end

  assign out_idx_ext = {{EntryIdxW{1'b0}}, out_idx_q};

  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.out_red      = out_rgb_q.red;
  assign rsp_o.out_green    = out_rgb_q.green;
  assign rsp_o.out_blue     = out_rgb_q.blue;
  assign rsp_o.out_alpha    = out_alpha_q;
  assign rsp_o.from_palette = out_pal_q;
  assign rsp_o.entry_index  = out_idx_ext[EntryIdxW-1:0];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(PALETTE_DEPTH))
    else $error("palette count beyond depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_FETCH) |-> count_q != '0)
    else $error("scan with empty palette");

  a_pass_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_pal_q) |-> out_idx_q == '0)
    else $error("pass-through result carries an entry index");

  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.operation == OP_MATCH && count_q == '0) |=>
      (out_valid_q && !out_pal_q && state_q == ST_IDLE))
    else $error("empty-palette match not passed through");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_last) |=> (out_valid_q && out_pal_q))
    else $error("scan finished without a palette result");
`endif

endmodule
